// ----- rtl/fmaf_pkg.sv -----
// ----------------------------------------------------------------------------
// fmaf_pkg
// Shared types and constants of the force moving-average filter: the control
// state encoding, sample and setting widths, and the setting-to-length table.
// ----------------------------------------------------------------------------
package fmaf_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int SETTING_W = 7;
    localparam int TLEN_W    = 6;

    localparam logic [SETTING_W-1:0] RESET_SETTING = 7'd100;

    typedef logic [TLEN_W-1:0] t_len;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIVIDE,
        ST_OUT
    } t_state;

    // Map a filter setting to its raw window length, before saturation.
    function automatic t_len length_of(input logic [SETTING_W-1:0] setting);
        t_len len;
        case (setting)
            7'd0:    len = 6'd40;
            7'd10:   len = 6'd35;
            7'd20:   len = 6'd30;
            7'd30:   len = 6'd25;
            7'd40:   len = 6'd20;
            7'd50:   len = 6'd15;
            7'd60:   len = 6'd10;
            7'd70:   len = 6'd7;
            7'd80:   len = 6'd4;
            7'd90:   len = 6'd2;
            default: len = 6'd1;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/force_moving_average_filter_top.sv -----
// ----------------------------------------------------------------------------
// force_moving_average_filter_top
// Boxcar averager for a signed 32-bit force stream with a table-selected
// window length and an iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_force_sample. A request is
//   taken at a rising edge with valid high and stall low. Stall is low only
//   while the block is idle, so one sample is in flight at a time.
//   Output channel: o_out_valid / i_out_stall with o_average_force. The result
//   sits in an output register, so a new sample is taken while an earlier
//   result still waits for the receiver; a stalled result holds its value.
//   Config channel: i_cfg_valid / o_cfg_ready with i_filter_setting. Ready is
//   high while idle. Writing a new setting clears the window, the running sum
//   and the write position; writing the active setting changes nothing.
// Processing steps:
//   After a request is taken, the block makes one sum update and write-back,
//   one divider load, SUM_W restoring-division steps and one output load;
//   the memory read rides on the accept edge, and the divider is bit-serial.
//   The output load waits while a stalled result still sits in the output
//   register, and a new request is taken only once the block is back in idle.
// Reset:
//   Setting 100 (window length 1), sum and position zero. The sample memory
//   is not swept: a wrap flag marks entries not written since the last clear,
//   and those read as zero.
// ----------------------------------------------------------------------------
module force_moving_average_filter_top #(
    parameter int MAX_WINDOW = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_force_sample,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_average_force,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_filter_setting
);

    localparam int SW    = fmaf_pkg::SAMPLE_W;
    localparam int POS_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    // Sum of MAX_WINDOW signed samples fits in SW + clog2(MAX_WINDOW) bits.
    localparam int SUM_W = SW + POS_W;
    localparam int CNT_W = $clog2(SUM_W);

    // Control state.
    fmaf_pkg::t_state r_state, n_state;

    // Configuration and window bookkeeping.
    logic [fmaf_pkg::SETTING_W-1:0] r_setting;
    logic [LEN_W-1:0]               r_len;
    logic [POS_W-1:0]               r_pos;
    logic                           r_wrapped;
    logic signed [SUM_W-1:0]        r_sum;

    // Sample memory, one read and one write port, registered read.
    logic [SW-1:0] r_window [MAX_WINDOW];
    logic [SW-1:0] r_rd_data;

    // Datapath registers.
    logic [SW-1:0]    r_sample;
    logic             r_neg;
    logic [SUM_W-1:0] r_quo;
    logic [LEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic [SW-1:0]    r_out_data;

    // Combinational helpers.
    logic                    in_take;
    logic                    cfg_take;
    logic                    cfg_change;
    fmaf_pkg::t_len          tbl_len;
    logic [LEN_W-1:0]        cfg_len;
    logic [SW-1:0]           old_sample;
    logic signed [SUM_W-1:0] new_sum;
    logic [LEN_W-1:0]        pos_inc;
    logic                    pos_wrap;
    logic [SUM_W-1:0]        sum_mag;
    logic [LEN_W:0]          rem_sh;
    logic                    rem_ge;
    logic [SUM_W-1:0]        quo_signed;
    logic                    out_free;

    assign o_in_stall      = (r_state != fmaf_pkg::ST_IDLE);
    assign o_cfg_ready     = (r_state == fmaf_pkg::ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_average_force = r_out_data;

    assign in_take    = i_in_valid && !o_in_stall;
    assign cfg_take   = i_cfg_valid && o_cfg_ready;
    assign cfg_change = cfg_take && (i_filter_setting != r_setting);

    // Saturate the table length to the window depth.
    assign tbl_len = fmaf_pkg::length_of(i_filter_setting);
    assign cfg_len = (int'(tbl_len) > MAX_WINDOW) ? LEN_W'(MAX_WINDOW)
                                                  : LEN_W'(tbl_len);

    // Entries not written since the last clear count as zero.
    assign old_sample = r_wrapped ? r_rd_data : '0;
    assign new_sum    = r_sum
                        - signed'({{(SUM_W-SW){old_sample[SW-1]}}, old_sample})
                        + signed'({{(SUM_W-SW){r_sample[SW-1]}}, r_sample});

    assign pos_inc  = LEN_W'(r_pos) + LEN_W'(1);
    assign pos_wrap = (pos_inc >= r_len);

    assign sum_mag = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;

    // One restoring-division step: shift in the next dividend bit, try subtract.
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_len});

    assign quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fmaf_pkg::ST_IDLE: begin
                if (in_take) begin
                    n_state = fmaf_pkg::ST_READ;
                end
            end
            fmaf_pkg::ST_READ: begin
                n_state = fmaf_pkg::ST_LOAD;
            end
            fmaf_pkg::ST_LOAD: begin
                n_state = fmaf_pkg::ST_DIVIDE;
            end
            fmaf_pkg::ST_DIVIDE: begin
                if (r_cnt == '0) begin
                    n_state = fmaf_pkg::ST_OUT;
                end
            end
            fmaf_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = fmaf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fmaf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fmaf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sample memory: read the oldest entry on accept, write the new one back.
    always_ff @(posedge i_clk) begin
        if (r_state == fmaf_pkg::ST_READ) begin
            r_window[r_pos] <= r_sample;
        end
        if (in_take) begin
            r_rd_data <= r_window[r_pos];
        end
    end

    // Configuration, running sum and write position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting <= fmaf_pkg::RESET_SETTING;
            r_len     <= LEN_W'(1);
            r_pos     <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
        end else if (cfg_change) begin
            r_setting <= i_filter_setting;
            r_len     <= cfg_len;
            r_pos     <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
        end else if (r_state == fmaf_pkg::ST_READ) begin
            r_sum <= new_sum;
            if (pos_wrap) begin
                r_pos     <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_pos <= POS_W'(pos_inc);
            end
        end
    end

    // Divider and sample capture.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_force_sample;
        end
        case (r_state)
            fmaf_pkg::ST_LOAD: begin
                r_neg <= r_sum[SUM_W-1];
                r_quo <= sum_mag;
                r_rem <= '0;
                r_cnt <= CNT_W'(SUM_W - 1);
            end
            fmaf_pkg::ST_DIVIDE: begin
                r_quo <= {r_quo[SUM_W-2:0], rem_ge};
                r_rem <= rem_ge ? LEN_W'(rem_sh - {1'b0, r_len}) : LEN_W'(rem_sh);
                r_cnt <= r_cnt - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Output register: load when empty or being drained, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == fmaf_pkg::ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fmaf_pkg::ST_OUT && out_free) begin
            r_out_data <= quo_signed[SW-1:0];
        end
    end

endmodule
